FILE: hdl/lpl_pkg.sv
package lpl_pkg;

    localparam int COORD_WIDTH_DEF       = 21;
    localparam int LOG_TABLE_ENTRIES_DEF = 256;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RX_GAIN     = 2'd0,
        CFG_SYSTEM_LOSS = 2'd1,
        CFG_WAVELENGTH  = 2'd2
    } t_cfg_idx;

    localparam logic signed [15:0] RX_GAIN_RST     = 16'sd0;
    localparam logic [15:0]        SYSTEM_LOSS_RST = 16'd256;
    localparam logic [19:0]        WAVELENGTH_RST  = 20'd125000;

    localparam int LGW = 23;
    localparam int VW  = 27;
    localparam int MW  = 54;
    localparam int PWW = 23;

    localparam int FAR_OFFSET = -30183;
    localparam int DB_SCALE   = 50504453;
    localparam int LG_BIAS    = 24 * 65536;
    localparam int OUT_MIN    = -262144;
    localparam int OUT_MAX    = 65535;
    localparam int DELAY_BITS = 10;
    localparam int DELAY_SQ   = 23040000;

    function automatic logic [16:0] lg_entry(input logic [63:0] m0);
        logic [63:0] m;
        logic [19:0] bits;
        logic [20:0] rnd;
        m    = m0;
        bits = '0;
        for (int k = 0; k < 20; k++) begin
            m    = (m * m) >> 30;
            bits = {bits[18:0], 1'b0};
            if (m >= (64'd1 << 31)) begin
                bits[0] = 1'b1;
                m       = m >> 1;
            end
        end
        rnd = {1'b0, bits} + 21'd8;
        return rnd[20:4];
    endfunction

    function automatic logic [5:0] msb_pos(input logic [63:0] x);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

endpackage

FILE: hdl/log_distance_path_loss_unit.sv
// Channel   Handshake                   Payload
// input     i_in_valid / o_in_ready     i_tx_dbm, i_tx_x..z, i_rx_x..z
// output    o_out_valid / i_out_ready   o_rx_power, o_prop_delay, o_near_field
// config    i_cfg_we (write only)       i_cfg_index, i_cfg_data
//
// The pipeline has 13 register stages, and a new beat is taken every cycle
// while the output is not stalled. The depth is set by the ten-step delay
// square root and the log2 lanes that run beside it. Reset is synchronous and
// active low; it empties the pipeline and restores the register defaults. A
// stall on the output holds every stage in place, so no beat is lost or
// repeated.
module log_distance_path_loss_unit #(
    parameter int COORD_WIDTH       = lpl_pkg::COORD_WIDTH_DEF,
    parameter int LOG_TABLE_ENTRIES = lpl_pkg::LOG_TABLE_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [15:0]                i_tx_dbm,
    input  logic signed [COORD_WIDTH-1:0]     i_tx_x,
    input  logic signed [COORD_WIDTH-1:0]     i_tx_y,
    input  logic signed [COORD_WIDTH-1:0]     i_tx_z,
    input  logic signed [COORD_WIDTH-1:0]     i_rx_x,
    input  logic signed [COORD_WIDTH-1:0]     i_rx_y,
    input  logic signed [COORD_WIDTH-1:0]     i_rx_z,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [18:0]                o_rx_power,
    output logic [9:0]                        o_prop_delay,
    output logic                              o_near_field,
    input  logic                              i_cfg_we,
    input  logic [lpl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lpl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int DW  = COORD_WIDTH + 1;
    localparam int AW  = COORD_WIDTH;
    localparam int QW  = 2 * COORD_WIDTH;
    localparam int SW  = 2 * COORD_WIDTH + 2;
    localparam int IW  = $clog2(LOG_TABLE_ENTRIES);
    localparam int NW  = IW + 1;
    localparam int PSW = 32 + NW;
    localparam int RW  = (SW > 48) ? SW : 48;
    localparam int CKW = 36;
    localparam int NST = 13;
    localparam int NB  = lpl_pkg::DELAY_BITS;
    localparam int LGW = lpl_pkg::LGW;
    localparam int VW  = lpl_pkg::VW;
    localparam int MW  = lpl_pkg::MW;
    localparam int PWW = lpl_pkg::PWW;

    // Log2 table, built at elaboration.
    logic [16:0] w_rom [0:LOG_TABLE_ENTRIES];
    for (genvar gi = 0; gi < LOG_TABLE_ENTRIES; gi++) begin : g_rom
        localparam logic [63:0] M0 =
            (64'd1 << 30) + ((64'(gi) << 30) / LOG_TABLE_ENTRIES);
        localparam logic [16:0] LV = lpl_pkg::lg_entry(M0);
        assign w_rom[gi] = LV;
    end
    assign w_rom[LOG_TABLE_ENTRIES] = 17'd65536;

    logic signed [15:0] r_rx_gain;
    logic [15:0]        r_system_loss;
    logic [19:0]        r_wavelength;
    logic [NST:1]       r_vld;
    logic               w_adv;

    assign w_adv       = !r_vld[NST] || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_vld[NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            r_rx_gain     <= lpl_pkg::RX_GAIN_RST;
            r_system_loss <= lpl_pkg::SYSTEM_LOSS_RST;
            r_wavelength  <= lpl_pkg::WAVELENGTH_RST;
        end else begin
            if (w_adv) begin
                r_vld <= {r_vld[NST-1:1], i_in_valid};
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lpl_pkg::CFG_RX_GAIN:     r_rx_gain     <= $signed(i_cfg_data[15:0]);
                    lpl_pkg::CFG_SYSTEM_LOSS: r_system_loss <= i_cfg_data[15:0];
                    lpl_pkg::CFG_WAVELENGTH:  r_wavelength  <= i_cfg_data[19:0];
                    default: ;
                endcase
            end
        end
    end

    // Stage 1: absolute differences and the near-field power.
    logic [AW-1:0]       r1_a [3];
    logic signed [16:0]  r_pw0 [1:11];
    // Stage 2: squares.  Stage 3: sum of squares.
    logic [QW-1:0]       r2_q [3];
    logic [SW-1:0]       r3_s;
    // Delay square root, stages 4 to 13.
    logic [RW-1:0]       r_sr [NB];
    logic [CKW-1:0]      r_sc [NB];
    logic [NB-1:0]       r_sk [NB];
    // Log2 lanes: distance, wavelength, system loss.
    logic [63:0]         r4_x [3];
    logic [5:0]          r4_p [3];
    logic [31:0]         r5_f [3];
    logic [5:0]          r5_p [3];
    logic [PSW-1:0]      r6_pos [3];
    logic [5:0]          r6_p [3];
    logic [16:0]         r7_lo [3];
    logic [16:0]         r7_dl [3];
    logic [31:0]         r7_rem [3];
    logic [5:0]          r7_p [3];
    logic [16:0]         r8_lo [3];
    logic [48:0]         r8_ip [3];
    logic [5:0]          r8_p [3];
    logic [LGW-1:0]      r9_lg [3];
    logic signed [VW-1:0]  r10_v;
    logic signed [MW-1:0]  r11_m;
    logic signed [PWW-1:0] r12_pw;
    logic                  r_near [4:12];
    logic signed [18:0]    r_rx_power;
    logic                  r_near_out;

    logic signed [DW-1:0]  n_diff [3];
    logic [DW-1:0]         n_neg [3];
    logic [63:0]           n_lx [3];
    logic [63:0]           n_sh [3];
    logic [RW-1:0]         n_t [NB];
    logic [RW-1:0]         n_rin [NB];
    logic [CKW-1:0]        n_cin [NB];
    logic [NB-1:0]         n_kin [NB];
    logic [IW-1:0]         n_idx [3];
    logic [16:0]           n_hi [3];
    logic [16:0]           n_lo [3];
    logic signed [VW-1:0]  n_v;
    logic signed [MW-1:0]  n_m;
    logic signed [PWW-1:0] n_db;
    logic signed [PWW-1:0] n_pw;
    logic signed [18:0]    n_sat;

    always_comb begin
        n_diff[0] = DW'(i_rx_x) - DW'(i_tx_x);
        n_diff[1] = DW'(i_rx_y) - DW'(i_tx_y);
        n_diff[2] = DW'(i_rx_z) - DW'(i_tx_z);
        for (int a = 0; a < 3; a++) begin
            n_neg[a] = -n_diff[a];
        end
        n_lx[0] = 64'(r3_s);
        n_lx[1] = (r_wavelength == '0) ? 64'd1 : 64'(r_wavelength);
        n_lx[2] = (r_system_loss == '0) ? 64'd1 : 64'(r_system_loss);
        for (int a = 0; a < 3; a++) begin
            n_sh[a]  = r4_x[a] << (6'd63 - r4_p[a]);
            n_idx[a] = r6_pos[a][32 +: IW];
            n_lo[a]  = w_rom[NW'(n_idx[a])];
            n_hi[a]  = w_rom[NW'(n_idx[a]) + NW'(1)];
        end
        for (int j = 0; j < NB; j++) begin
            if (j == 0) begin
                n_rin[j] = RW'(r3_s);
                n_cin[j] = '0;
                n_kin[j] = '0;
            end else begin
                n_rin[j] = r_sr[j-1];
                n_cin[j] = r_sc[j-1];
                n_kin[j] = r_sk[j-1];
            end
            n_t[j] = (RW'(n_cin[j]) << (NB - j))
                   + (RW'(lpl_pkg::DELAY_SQ) << (2 * (NB - 1 - j)));
        end
        n_v = (VW'(r9_lg[1]) <<< 2) - (VW'(r9_lg[2]) <<< 1)
            - VW'(r9_lg[0]) - (VW'(r9_lg[0]) <<< 1) + VW'(lpl_pkg::LG_BIAS);
        n_m  = r11_m + (MW'(1) <<< 32);
        n_db = PWW'(n_m >>> 33);
        n_pw = PWW'(r_pw0[11]);
        if (!r_near[11]) begin
            n_pw = n_pw + PWW'(lpl_pkg::FAR_OFFSET) + n_db;
        end
        if (r12_pw < PWW'(lpl_pkg::OUT_MIN)) begin
            n_sat = 19'(lpl_pkg::OUT_MIN);
        end else if (r12_pw > PWW'(lpl_pkg::OUT_MAX)) begin
            n_sat = 19'(lpl_pkg::OUT_MAX);
        end else begin
            n_sat = r12_pw[18:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int a = 0; a < 3; a++) begin
                r1_a[a] <= n_diff[a][DW-1] ? n_neg[a][AW-1:0] : n_diff[a][AW-1:0];
                r2_q[a] <= QW'(r1_a[a]) * QW'(r1_a[a]);
            end
            r_pw0[1] <= 17'(i_tx_dbm) + 17'(r_rx_gain);
            for (int k = 2; k <= 11; k++) begin
                r_pw0[k] <= r_pw0[k-1];
            end
            r3_s <= SW'(r2_q[0]) + SW'(r2_q[1]) + SW'(r2_q[2]);

            for (int j = 0; j < NB; j++) begin
                if (n_rin[j] >= n_t[j]) begin
                    r_sr[j] <= n_rin[j] - n_t[j];
                    r_sc[j] <= n_cin[j] + (CKW'(lpl_pkg::DELAY_SQ) << (NB - 1 - j));
                    r_sk[j] <= n_kin[j] | (NB'(1) << (NB - 1 - j));
                end else begin
                    r_sr[j] <= n_rin[j];
                    r_sc[j] <= n_cin[j];
                    r_sk[j] <= n_kin[j];
                end
            end

            for (int a = 0; a < 3; a++) begin
                r4_x[a]   <= n_lx[a];
                r4_p[a]   <= lpl_pkg::msb_pos(n_lx[a]);
                r5_f[a]   <= n_sh[a][62:31];
                r5_p[a]   <= r4_p[a];
                r6_pos[a] <= PSW'(r5_f[a]) * PSW'(LOG_TABLE_ENTRIES);
                r6_p[a]   <= r5_p[a];
                r7_lo[a]  <= n_lo[a];
                r7_dl[a]  <= n_hi[a] - n_lo[a];
                r7_rem[a] <= r6_pos[a][31:0];
                r7_p[a]   <= r6_p[a];
                r8_lo[a]  <= r7_lo[a];
                r8_ip[a]  <= 49'(r7_dl[a]) * 49'(r7_rem[a]);
                r8_p[a]   <= r7_p[a];
                r9_lg[a]  <= LGW'({r8_p[a], 16'd0}) + LGW'(r8_lo[a]) + LGW'(r8_ip[a][48:32]);
            end
            r10_v  <= n_v;
            r11_m  <= MW'(r10_v) * MW'(lpl_pkg::DB_SCALE);
            r12_pw <= n_pw;

            r_near[4] <= (r3_s <= SW'(256));
            for (int k = 5; k <= 12; k++) begin
                r_near[k] <= r_near[k-1];
            end
            r_rx_power <= n_sat;
            r_near_out <= r_near[12];
        end
    end

    assign o_rx_power   = r_rx_power;
    assign o_prop_delay = r_sk[NB-1];
    assign o_near_field = r_near_out;

`ifndef ASSERT_OFF
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> r_vld == '0)
        else $error("pipeline not empty after reset");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld) && $stable(r_rx_power) && $stable(r_sk[NB-1]))
        else $error("pipeline moved during a stall");
    a_near_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_near_field |-> o_prop_delay == '0)
        else $error("near-field beat with nonzero delay");
    a_near_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_near_field |-> o_rx_power >= -19'sd65536 && o_rx_power <= 19'sd65534)
        else $error("near-field power out of range");
`endif

endmodule

FILE: tb/log_distance_path_loss_unit_tb.sv
module log_distance_path_loss_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = lpl_pkg::COORD_WIDTH_DEF;
    localparam int NT = lpl_pkg::LOG_TABLE_ENTRIES_DEF;

    typedef struct {
        logic signed [15:0]   tx_dbm;
        logic signed [CW-1:0] tx_x, tx_y, tx_z, rx_x, rx_y, rx_z;
    } t_link;

    typedef struct {
        logic signed [18:0] rx_power;
        logic [9:0]         prop_delay;
        logic               near_field;
    } t_rx;

    int unsigned err_count = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    class path_loss_scoreboard;
        longint unsigned log_rom[NT+1];
        longint          gain_q8;
        longint unsigned loss_q8;
        longint unsigned lambda_um;
        t_rx             pending[$];

        function new();
            longint unsigned m;
            longint unsigned bits;
            for (int i = 0; i < NT; i++) begin
                m = (64'd1 << 30) + ((longint'(i) << 30) / NT);
                bits = 0;
                for (int k = 0; k < 20; k++) begin
                    m = (m * m) >> 30;
                    bits = bits << 1;
                    if (m >= (64'd1 << 31)) begin
                        bits = bits | 1;
                        m = m >> 1;
                    end
                end
                log_rom[i] = (bits + 8) >> 4;
            end
            log_rom[NT] = 65536;
            gain_q8 = 0;
            loss_q8 = 256;
            lambda_um = 125000;
        endfunction

        function void set_reg(lpl_pkg::t_cfg_idx idx, logic [19:0] val);
            case (idx)
                lpl_pkg::CFG_RX_GAIN:     gain_q8 = longint'($signed(val[15:0]));
                lpl_pkg::CFG_SYSTEM_LOSS: loss_q8 = val[15:0];
                lpl_pkg::CFG_WAVELENGTH:  lambda_um = val;
                default: ;
            endcase
        endfunction

        function longint log2_q16(longint unsigned x);
            int p;
            longint unsigned f, pos, idx, rem, lo, hi;
            if (x == 0) x = 1;
            p = 63;
            while (x[p] == 1'b0) p--;
            if (p >= 32) f = x >> (p - 32);
            else f = x << (32 - p);
            f = f & 64'hFFFF_FFFF;
            pos = f * NT;
            idx = pos >> 32;
            rem = pos & 64'hFFFF_FFFF;
            if (idx >= NT) idx = NT - 1;
            lo = log_rom[idx];
            hi = log_rom[idx+1];
            return longint'(p) * 65536 + longint'(lo + (((hi - lo) * rem) >> 32));
        endfunction

        function longint unsigned floor_sqrt(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_link(t_link l);
            longint unsigned s, mag, dly;
            longint d, pw, v, t;
            t_rx r;
            s = 0;
            d = longint'(l.rx_x) - longint'(l.tx_x);
            mag = d < 0 ? -d : d;
            s += mag * mag;
            d = longint'(l.rx_y) - longint'(l.tx_y);
            mag = d < 0 ? -d : d;
            s += mag * mag;
            d = longint'(l.rx_z) - longint'(l.tx_z);
            mag = d < 0 ? -d : d;
            s += mag * mag;
            pw = longint'(l.tx_dbm) + gain_q8;
            r.near_field = (s <= 256);
            if (!r.near_field) begin
                v = 4 * log2_q16(lambda_um == 0 ? 1 : lambda_um)
                    - 2 * log2_q16(loss_q8 == 0 ? 1 : loss_q8)
                    - 3 * log2_q16(s) + 24 * 65536;
                t = v * 50504453 + (64'sd1 << 32);
                if (t >= 0) t = t >>> 33;
                else t = -((-t + (64'sd1 << 33) - 1) >>> 33);
                pw += -30183 + t;
            end
            if (pw < -262144) pw = -262144;
            if (pw > 65535) pw = 65535;
            r.rx_power = pw[18:0];
            dly = floor_sqrt(s) / 4800;
            if (dly > 1023) dly = 1023;
            r.prop_delay = dly[9:0];
            pending.push_back(r);
        endfunction

        task check_result(t_rx got);
            t_rx want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected beat", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.rx_power !== want.rx_power)
                report_mismatch("rx_power", got.rx_power, want.rx_power);
            if (got.prop_delay !== want.prop_delay)
                report_mismatch("prop_delay", got.prop_delay, want.prop_delay);
            if (got.near_field !== want.near_field)
                report_mismatch("near_field", got.near_field, want.near_field);
        endtask
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_in_valid = 0;
    logic                 o_in_ready;
    logic signed [15:0]   i_tx_dbm = 0;
    logic signed [CW-1:0] i_tx_x = 0, i_tx_y = 0, i_tx_z = 0;
    logic signed [CW-1:0] i_rx_x = 0, i_rx_y = 0, i_rx_z = 0;
    logic                 o_out_valid;
    logic                 i_out_ready = 0;
    logic signed [18:0]   o_rx_power;
    logic [9:0]           o_prop_delay;
    logic                 o_near_field;
    logic                 i_cfg_we = 0;
    logic [lpl_pkg::CFG_IDX_W-1:0]  i_cfg_index = 0;
    logic [lpl_pkg::CFG_DATA_W-1:0] i_cfg_data = 0;

    path_loss_scoreboard sb = new();
    int idle_pct = 29;

    log_distance_path_loss_unit u_top (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        t_rx r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            r.rx_power = o_rx_power;
            r.prop_delay = o_prop_delay;
            r.near_field = o_near_field;
            sb.check_result(r);
        end
        if (i_rst_n) i_out_ready <= ($urandom_range(99) >= idle_pct);
    end

    function automatic logic [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return CW'($urandom);
            1: return CW'($signed($urandom_range(64)) - 32);
            default: return CW'($signed($urandom_range(4000)) - 2000);
        endcase
    endfunction

    task automatic write_reg(input lpl_pkg::t_cfg_idx idx, input logic [19:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_reg(idx, val);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_link(input t_link l);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid <= 1;
        i_tx_dbm <= l.tx_dbm;
        i_tx_x <= l.tx_x;
        i_tx_y <= l.tx_y;
        i_tx_z <= l.tx_z;
        i_rx_x <= l.rx_x;
        i_rx_y <= l.rx_y;
        i_rx_z <= l.rx_z;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_link(l);
    endtask

    task automatic send_random(input int count);
        t_link l;
        int mode;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(2);
            l.tx_dbm = 16'($urandom);
            l.tx_x = rand_coord(mode);
            l.tx_y = rand_coord(mode);
            l.tx_z = rand_coord(mode);
            l.rx_x = rand_coord(mode);
            l.rx_y = rand_coord(mode);
            l.rx_z = rand_coord(mode);
            send_link(l);
        end
    endtask

    task automatic send_coords(input logic signed [15:0] p, input int dx, input int dy,
                               input int dz, input int base);
        t_link l;
        l.tx_dbm = p;
        l.tx_x = CW'(base);
        l.tx_y = CW'(base);
        l.tx_z = CW'(base);
        l.rx_x = CW'(base + dx);
        l.rx_y = CW'(base + dy);
        l.rx_z = CW'(base + dz);
        send_link(l);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        i_out_ready <= 1;

        send_coords(16'sh7FFF, 0, 0, 0, 0);
        send_coords(-16'sh8000, 16, 0, 0, 0);
        send_coords(0, 16, 1, 0, 0);
        send_coords(100, 9, 9, 9, -5);
        send_coords(-16'sh8000, 4800, 0, 0, 0);
        send_coords(0, 4799, 0, 0, 0);
        send_coords(0, 100, 200, 300, 1000);
        send_coords(16'sh7FFF, 1048575, 0, 0, 0);
        send_coords(-16'sh8000, -1048576, -1048576, -1048576, 1048575);
        send_coords(0, -1048576, -1048576, -1048576, 1048575);
        send_coords(16'sh7FFF, 17, 0, 0, -1048576);
        send_random(10);
        drain();

        write_reg(lpl_pkg::CFG_RX_GAIN, 20'h07FFF);
        write_reg(lpl_pkg::CFG_SYSTEM_LOSS, 20'd0);
        write_reg(lpl_pkg::CFG_WAVELENGTH, 20'd0);
        send_random(60);
        drain();
        write_reg(lpl_pkg::CFG_RX_GAIN, 20'h08000);
        write_reg(lpl_pkg::CFG_SYSTEM_LOSS, 20'hFFFF);
        write_reg(lpl_pkg::CFG_WAVELENGTH, 20'hFFFFF);
        send_random(60);
        drain();
        write_reg(lpl_pkg::CFG_SYSTEM_LOSS, 20'd1);
        write_reg(lpl_pkg::CFG_WAVELENGTH, 20'd1000);
        send_random(60);
        drain();

        idle_pct = 0;
        write_reg(lpl_pkg::CFG_RX_GAIN, 20'd300);
        write_reg(lpl_pkg::CFG_SYSTEM_LOSS, 20'd256);
        write_reg(lpl_pkg::CFG_WAVELENGTH, 20'd1000000);
        send_random(300);
        drain();
        idle_pct = 29;

        for (int ph = 0; ph < 5; ph++) begin
            write_reg(lpl_pkg::CFG_RX_GAIN, 20'($urandom));
            write_reg(lpl_pkg::CFG_SYSTEM_LOSS, 20'($urandom_range(65535, 256)));
            write_reg(lpl_pkg::CFG_WAVELENGTH, 20'($urandom_range(1000000, 1000)));
            send_random(210);
            drain();
        end

        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
